>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk_i, rst_ni, prop) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("assertion failed: %m");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, clk_i, rst_ni, cond) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
		else $error("forbidden condition seen: %m");

`endif

>>> rtl/core/tas_pkg.sv
// shared types, constants and helpers of the tensor axis sum block
package tas_pkg;

	localparam int DIM_COUNT       = 4;
	localparam int MAX_RANK        = 4;
	localparam int COORD_W         = 10;
	localparam int SIZE_W          = 11;
	localparam int AXIS_W          = 2;
	localparam int SUM_W           = 48;
	localparam int OUT_POS_W       = 10;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 11;
	localparam int ACC_DEPTH_DEF   = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [SIZE_W-1:0] COORD_MAX = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM0 = 3'd0,
		REG_DIM1 = 3'd1,
		REG_DIM2 = 3'd2,
		REG_DIM3 = 3'd3,
		REG_AXIS = 3'd4
	} cfg_reg_e;

	// per-item control flags travelling down the pipeline
	typedef struct packed {
		logic first;  // axis coordinate is zero: load instead of add
		logic emit;   // axis coordinate is last: sum is finished
		logic last;   // every coordinate is last: end of tensor
	} item_flags_t;

	// zero counts as one, anything above the coordinate range saturates
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] s;
		s = raw;
		if (raw == '0) begin
			s = SIZE_W'(1);
		end else if (raw > COORD_MAX) begin
			s = COORD_MAX;
		end
		return s;
	endfunction

endpackage

>>> rtl/core/tas_ram.sv
// generic single-write, single-read ram with registered read data
module tas_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/tensor_axis_sum.sv
// tensor axis sum: row-major tensor reduced along one configured axis
//
//   channel   | dir | beat contents
//   ----------+-----+-----------------------------------------------------------
//   s_axis    | in  | tdata: value (VALUE_WIDTH, signed Q16.16), zero pad to bytes
//   m_axis    | out | tdata: sum [47:0], out_position [57:48], zero [63:58];
//             |     | tlast: last_of_tensor
//   cfg       | in  | cfg_index selects register, cfg_data holds the new value
//
// one element per cycle unless the output stalls; a finished sum reaches m_axis
// through the output register. the accumulator ram takes one read and one write
// a cycle, and a write that meets a read of the same entry is forwarded.
// reset clears counters, config and valid bits only; accumulator contents stay
// undefined and need no clearing pass. the whole pipeline holds only while a
// finished sum waits in the output register and the next one is ready behind it.
`include "assert_macros.svh"

module tensor_axis_sum #(
	parameter int ACC_DEPTH   = tas_pkg::ACC_DEPTH_DEF,   // power of two
	parameter int VALUE_WIDTH = tas_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input element stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // value
	// finished sums
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [63:0]                          m_axis_tdata,  // sum, out_position
	output logic                                 m_axis_tlast,  // last_of_tensor
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tas_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tas_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import tas_pkg::*;

	localparam int ADDR_W = $clog2(ACC_DEPTH);
	localparam int PROD_W = ADDR_W + SIZE_W;

	// one horner step of the output position, reduced to the ram depth
	function automatic logic [ADDR_W-1:0] pos_step(input logic [ADDR_W-1:0]  p,
	                                               input logic [SIZE_W-1:0]  s,
	                                               input logic [COORD_W-1:0] c);
		logic [PROD_W-1:0] acc;
		acc = {{SIZE_W{1'b0}}, p} * {{ADDR_W{1'b0}}, s}
		    + {{(PROD_W-COORD_W){1'b0}}, c};
		return acc[ADDR_W-1:0];
	endfunction

	// configuration registers
	logic [SIZE_W-1:0]  dim_q [DIM_COUNT];
	logic [AXIS_W-1:0]  axis_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIM_COUNT; d++) begin
				dim_q[d] <= SIZE_W'(1);
			end
			axis_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIM0: dim_q[0] <= cfg_data;
				REG_DIM1: dim_q[1] <= cfg_data;
				REG_DIM2: dim_q[2] <= cfg_data;
				REG_DIM3: dim_q[3] <= cfg_data;
				REG_AXIS: axis_q   <= cfg_data[AXIS_W-1:0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// coordinate tracking at the input
	logic [COORD_W-1:0] crd_q    [DIM_COUNT];
	logic [COORD_W-1:0] crd_nxt  [DIM_COUNT];
	logic [SIZE_W-1:0]  eff      [DIM_COUNT];
	logic [SIZE_W-1:0]  sz_red   [DIM_COUNT];  // axis dimension taken as size one
	logic [COORD_W-1:0] crd_red  [DIM_COUNT];  // axis coordinate taken as zero
	logic [DIM_COUNT-1:0] at_last;
	logic               carry;
	item_flags_t        fl_in;

	always_comb begin
		for (int d = 0; d < DIM_COUNT; d++) begin
			eff[d]     = (d >= MAX_RANK) ? SIZE_W'(1) : eff_size(dim_q[d]);
			at_last[d] = ({1'b0, crd_q[d]} + SIZE_W'(1)) >= eff[d];
			sz_red[d]  = (AXIS_W'(d) == axis_q) ? SIZE_W'(1) : eff[d];
			crd_red[d] = (AXIS_W'(d) == axis_q) ? '0 : crd_q[d];
		end
		fl_in.first = (crd_q[axis_q] == '0);
		fl_in.emit  = at_last[axis_q];
		fl_in.last  = &at_last;
		// innermost dimension counts fastest, wrap carries outward
		carry = 1'b1;
		for (int d = DIM_COUNT - 1; d >= 0; d--) begin
			crd_nxt[d] = crd_q[d];
			if (carry) begin
				if (at_last[d]) begin
					crd_nxt[d] = '0;
				end else begin
					crd_nxt[d] = crd_q[d] + COORD_W'(1);
					carry      = 1'b0;
				end
			end
		end
	end

	// pipeline control
	logic en;
	logic in_take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	item_flags_t fl_s1, fl_s2, fl_s3, fl_s4, fl_s5;
	logic m_valid_q;

	// stall only when the finished sum in the last stage has nowhere to go
	assign en            = !(v_s5 && fl_s5.emit && m_valid_q && !m_axis_tready);
	assign s_axis_tready = en;
	assign in_take       = s_axis_tvalid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIM_COUNT; d++) begin
				crd_q[d] <= '0;
			end
		end else if (in_take) begin
			for (int d = 0; d < DIM_COUNT; d++) begin
				crd_q[d] <= crd_nxt[d];
			end
		end
	end

	// position pipeline payload
	logic signed [VALUE_WIDTH-1:0] val_s1, val_s2, val_s3, val_s4, val_s5;
	logic [ADDR_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [COORD_W-1:0] crd_s1 [1:3];
	logic [SIZE_W-1:0]  sz_s1  [1:3];
	logic [COORD_W-1:0] crd_s2 [2:3];
	logic [SIZE_W-1:0]  sz_s2  [2:3];
	logic [COORD_W-1:0] crd3_s3;
	logic [SIZE_W-1:0]  sz3_s3;

	// read-modify-write stage
	logic              fwd_hit_s5;
	logic [SUM_W-1:0]  fwd_data_s5;
	logic [SUM_W-1:0]  ram_rdata;
	logic [SUM_W-1:0]  base;
	logic [SUM_W-1:0]  acc_new;
	logic signed [SUM_W-1:0] vext;
	logic              rd_en;
	logic              wr_en;
	logic              fwd_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			fwd_hit_s5 <= 1'b0;
		end else if (en) begin
			v_s1       <= s_axis_tvalid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			fwd_hit_s5 <= fwd_match;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: outermost coordinate starts the position
			val_s1 <= s_axis_tdata[VALUE_WIDTH-1:0];
			fl_s1  <= fl_in;
			pos_s1 <= ADDR_W'(crd_red[0]);
			for (int d = 1; d <= 3; d++) begin
				crd_s1[d] <= crd_red[d];
				sz_s1[d]  <= sz_red[d];
			end
			// stages 2 to 4: one multiply-add each
			val_s2    <= val_s1;
			fl_s2     <= fl_s1;
			pos_s2    <= pos_step(pos_s1, sz_s1[1], crd_s1[1]);
			crd_s2[2] <= crd_s1[2];
			crd_s2[3] <= crd_s1[3];
			sz_s2[2]  <= sz_s1[2];
			sz_s2[3]  <= sz_s1[3];
			val_s3    <= val_s2;
			fl_s3     <= fl_s2;
			pos_s3    <= pos_step(pos_s2, sz_s2[2], crd_s2[2]);
			crd3_s3   <= crd_s2[3];
			sz3_s3    <= sz_s2[3];
			val_s4    <= val_s3;
			fl_s4     <= fl_s3;
			pos_s4    <= pos_step(pos_s3, sz3_s3, crd3_s3);
			// stage 5: ram data arrives, forward the write it raced with
			val_s5      <= val_s4;
			fl_s5       <= fl_s4;
			pos_s5      <= pos_s4;
			fwd_data_s5 <= acc_new;
		end
	end

	assign fwd_match = v_s4 && v_s5 && (pos_s4 == pos_s5);
	assign rd_en     = en && v_s4;
	assign wr_en     = en && v_s5;

	assign vext    = SUM_W'(val_s5);
	assign base    = fwd_hit_s5 ? fwd_data_s5 : ram_rdata;
	assign acc_new = fl_s5.first ? vext : (base + vext);

	tas_ram #(
		.WIDTH (SUM_W),
		.DEPTH (ACC_DEPTH)
	) u_acc_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_s5),
		.wr_data (acc_new),
		.rd_en   (rd_en),
		.rd_addr (pos_s4),
		.rd_data (ram_rdata)
	);

	// output register
	logic [SUM_W-1:0]     sum_q;
	logic [OUT_POS_W-1:0] opos_q;
	logic                 olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en && v_s5 && fl_s5.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5 && fl_s5.emit) begin
			sum_q   <= acc_new;
			opos_q  <= OUT_POS_W'(pos_s5);
			olast_q <= fl_s5.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(64-SUM_W-OUT_POS_W){1'b0}}, opos_q, sum_q};
	assign m_axis_tlast  = olast_q;

	// a forwarded value always belongs to a live item in the last stage
	`ASSERT_CLK(a_fwd_live, clk, arst_n, fwd_hit_s5 |-> v_s5)
	// a ram read is always followed by its item in the last stage
	`ASSERT_CLK(a_read_lands, clk, arst_n, rd_en |=> v_s5)
	// end of tensor is only ever flagged on a finished sum
	`ASSERT_NEVER(a_last_needs_emit, clk, arst_n, v_s5 && fl_s5.last && !fl_s5.emit)

endmodule
